@@ sv/scope_trigger_capture_core_assert.svh @@
// assertion macros used by the checker file
`ifndef SCOPE_TRIGGER_CAPTURE_CORE_ASSERT_SVH
`define SCOPE_TRIGGER_CAPTURE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Codes, field widths and pipeline types of the scope trigger capture core.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int INDEX_W   = 10;
    localparam int KIND_W    = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // word kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REARM  = 2'd2;

    // trigger modes
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE  = 8'd1;

    localparam logic [SAMPLE_W-1:0] LEVEL_RESET = 8'd128;

    // flags carried from the update stage to the result register
    typedef struct packed {
        logic               capture_done;
        logic               triggered_now;
        logic               is_read;
        logic [INDEX_W-1:0] trigger_place;
        logic               armed_flag;
    } stc_flags_t;

endpackage

@@ sv/stc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/scope_trigger_capture_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_trigger_capture_core
// Two-channel edge-triggered capture with pretrigger history.
// ----------------------------------------------------------------------------
// Input words (s_valid/s_ready) are samples, aligned read requests or rearm
// commands; each one produces exactly one result word on m_valid/m_ready.
// Configuration (trigger level, trigger mode) is written through
// cfg_valid/cfg_ready with cfg_index and cfg_wdata, always ready; the user
// writes only while no word is in flight, which the block does not enforce.
// A write to either register, once the first pass of the store is complete,
// restarts capture, or in stop mode returns to filling without arming.
// Control state, the stage register and the sample store read (registered
// RAM read port) load on acceptance; the result register and m_valid load
// as the stage advances. Throughput is one word per cycle without stalls.
// If the receiver stalls, the result register and the stage behind it hold
// and s_ready drops once both are full; nothing is lost or repeated.
// Reset empties the pipeline, clears the pointer, previous samples and
// trigger address, loads the full count and starts the first filling pass;
// the store itself is not cleared. STORE_SAMPLES must be a power of two.
// ----------------------------------------------------------------------------
module scope_trigger_capture_core
    import stc_pkg::*;
#(
    parameter int STORE_SAMPLES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KIND_W-1:0]    s_kind,
    input  logic                 s_channel,
    input  logic [SAMPLE_W-1:0]  s_sample_value,
    input  logic [INDEX_W-1:0]   s_read_index,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_capture_done,
    output logic                 m_triggered_now,
    output logic [SAMPLE_W-1:0]  m_read_data,
    output logic [INDEX_W-1:0]   m_trigger_place,
    output logic                 m_armed_flag,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(STORE_SAMPLES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(STORE_SAMPLES);
    localparam logic [CW-1:0] CNT_HALF = CW'(STORE_SAMPLES / 2);
    localparam logic [CW-1:0] CNT_POST = CW'(STORE_SAMPLES / 2 - 1);
    localparam logic [AW-1:0] ADDR_HALF = AW'(STORE_SAMPLES / 2);

    typedef enum logic [1:0] {
        PH_FILL,
        PH_ARMED,
        PH_POST,
        PH_FROZEN
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       wptr_reg, wptr_next;
    logic [AW-1:0]       taddr_reg, taddr_next;
    logic [SAMPLE_W-1:0] prev_reg [2];
    logic [SAMPLE_W-1:0] level_reg, level_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;

    logic                s_fire, cfg_fire, stage_adv;
    logic                stage_valid_reg;
    stc_flags_t          stage_reg, stage_next;

    logic                m_valid_reg;
    stc_flags_t          m_flags_reg;
    logic [SAMPLE_W-1:0] m_data_reg;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic [SAMPLE_W-1:0] prev_sel;
    logic [CW-1:0]       count_dec;
    logic                crossing;
    logic                done_now, trig_now;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign stage_adv = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !stage_valid_reg || stage_adv;
    assign s_fire    = s_valid && s_ready;

    assign prev_sel  = prev_reg[s_channel];
    assign count_dec = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
    assign crossing  = (s_sample_value >= level_reg) && (prev_sel < level_reg);

    assign ram_raddr = taddr_reg - ADDR_HALF + AW'(s_read_index);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        wptr_next  = wptr_reg;
        taddr_next = taddr_reg;
        level_next = level_reg;
        mode_next  = mode_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        done_now   = 1'b0;
        trig_now   = 1'b0;

        if (cfg_fire) begin
            if (cfg_index == REG_TRIGGER_LEVEL) begin
                level_next = cfg_wdata;
            end else if (cfg_index == REG_TRIGGER_MODE) begin
                mode_next = cfg_wdata[MODE_W-1:0];
            end
            // writes past the list do nothing; first-pass writes only set the value
            if ((cfg_index == REG_TRIGGER_LEVEL || cfg_index == REG_TRIGGER_MODE) &&
                !(phase_reg == PH_FILL && count_reg != '0)) begin
                if (mode_next == MODE_STOP) begin
                    phase_next = PH_FILL;
                    count_next = '0;
                end else begin
                    phase_next = PH_ARMED;
                    count_next = CNT_FULL;
                end
            end
        end else if (s_fire) begin
            case (s_kind)
                KIND_SAMPLE: begin
                    if (phase_reg != PH_FROZEN) begin
                        ram_we    = 1'b1;
                        wptr_next = wptr_reg + AW'(1);
                    end
                    case (phase_reg)
                        PH_FILL: begin
                            count_next = count_dec;
                            if (count_reg != '0 && count_dec == '0 &&
                                mode_reg != MODE_STOP) begin
                                phase_next = PH_ARMED;
                                count_next = CNT_FULL;
                            end
                        end
                        PH_ARMED: begin
                            if (crossing ||
                                (mode_reg == MODE_AUTO && count_dec <= CNT_HALF)) begin
                                trig_now   = 1'b1;
                                taddr_next = wptr_reg;
                                phase_next = PH_POST;
                                count_next = CNT_POST;
                            end else if (count_dec == '0) begin
                                count_next = CNT_FULL;
                            end else begin
                                count_next = count_dec;
                            end
                        end
                        PH_POST: begin
                            count_next = count_dec;
                            if (count_dec == '0) begin
                                phase_next = PH_FROZEN;
                                done_now   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                KIND_READ: begin
                    ram_re = 1'b1;
                end
                KIND_REARM: begin
                    if (phase_reg == PH_FROZEN &&
                        (mode_reg == MODE_AUTO || mode_reg == MODE_NORMAL)) begin
                        phase_next = PH_ARMED;
                        count_next = CNT_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        stage_next.capture_done  = done_now;
        stage_next.triggered_now = trig_now;
        stage_next.is_read       = (s_kind == KIND_READ);
        stage_next.trigger_place = INDEX_W'(taddr_next);
        stage_next.armed_flag    = (phase_next == PH_ARMED);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FILL;
            count_reg       <= CNT_FULL;
            wptr_reg        <= '0;
            taddr_reg       <= '0;
            prev_reg[0]     <= '0;
            prev_reg[1]     <= '0;
            level_reg       <= LEVEL_RESET;
            mode_reg        <= MODE_AUTO;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            wptr_reg  <= wptr_next;
            taddr_reg <= taddr_next;
            level_reg <= level_next;
            mode_reg  <= mode_next;
            if (s_fire && s_kind == KIND_SAMPLE) begin
                prev_reg[s_channel] <= s_sample_value;
            end

            if (s_fire) begin
                stage_valid_reg <= 1'b1;
            end else if (stage_adv) begin
                stage_valid_reg <= 1'b0;
            end

            if (stage_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stage_reg <= stage_next;
        end
        if (stage_adv) begin
            m_flags_reg <= stage_reg;
            m_data_reg  <= stage_reg.is_read ? ram_rdata : '0;
        end
    end

    stc_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(STORE_SAMPLES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wptr_reg),
        .wdata(s_sample_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_capture_done  = m_flags_reg.capture_done;
    assign m_triggered_now = m_flags_reg.triggered_now;
    assign m_read_data     = m_data_reg;
    assign m_trigger_place = m_flags_reg.trigger_place;
    assign m_armed_flag    = m_flags_reg.armed_flag;

endmodule

@@ sv/stc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks on the result channel of the scope trigger capture core.
// ----------------------------------------------------------------------------
`include "scope_trigger_capture_core_assert.svh"

module stc_checker
    import stc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_capture_done,
    input logic                m_triggered_now,
    input logic [SAMPLE_W-1:0] m_read_data,
    input logic [INDEX_W-1:0]  m_trigger_place,
    input logic                m_armed_flag
);

    // a stalled result word holds
    `STC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_trigger_place) && $stable(m_capture_done), "result word changed while stalled")

    // a freezing sample leaves the block disarmed
    `STC_ASSERT_NOW(a_done_disarmed, m_valid && m_capture_done, !m_armed_flag, "armed after capture froze")

    // a trigger moves to post-trigger, never still armed
    `STC_ASSERT_NOW(a_trig_disarmed, m_valid && m_triggered_now, !m_armed_flag, "armed after trigger")

    // trigger and freeze cannot come from the same sample
    `STC_ASSERT_NOW(a_trig_not_done, m_valid && m_triggered_now, !m_capture_done, "trigger and freeze together")

endmodule

bind scope_trigger_capture_core stc_checker u_stc_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scope trigger capture core.
// Drives sample, read and rearm words with random gaps against a receiver
// that stalls at random. A behavioural model of the store, pointer, trigger
// search and capture phases predicts every result word, and a checker
// compares each one field by field. Directed tests cover the first pass,
// stop, normal, auto and single modes, then random capture rounds follow
// with register rewrites between them.
// ----------------------------------------------------------------------------
module tb;
    import stc_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        PH_FILLING, PH_ARMED, PH_POST_TRIGGER, PH_FROZEN
    } capture_phase_t;

    typedef struct packed {
        logic                done;
        logic                trig;
        logic [SAMPLE_W-1:0] data;
        logic [INDEX_W-1:0]  place;
        logic                armed;
    } capture_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KIND_W-1:0]    s_kind = KIND_SAMPLE;
    logic                 s_channel = 1'b0;
    logic [SAMPLE_W-1:0]  s_sample_value = '0;
    logic [INDEX_W-1:0]   s_read_index = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_capture_done;
    logic                 m_triggered_now;
    logic [SAMPLE_W-1:0]  m_read_data;
    logic [INDEX_W-1:0]   m_trigger_place;
    logic                 m_armed_flag;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    // model of the capture state
    logic [SAMPLE_W-1:0] capture_mem [STORE_DEPTH];
    logic [INDEX_W-1:0]  wr_ptr = '0;
    logic [SAMPLE_W-1:0] prev_sample [2] = '{8'd0, 8'd0};
    logic [10:0]         remaining = 11'(STORE_DEPTH);
    capture_phase_t      phase = PH_FILLING;
    logic [INDEX_W-1:0]  trig_addr = '0;
    logic [SAMPLE_W-1:0] trig_level = LEVEL_RESET;
    logic [MODE_W-1:0]   trig_mode = MODE_AUTO;

    capture_result_t pending_results [$];
    int  error_count = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    bit  steady = 1'b0;

    scope_trigger_capture_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_channel       (s_channel),
        .s_sample_value  (s_sample_value),
        .s_read_index    (s_read_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_capture_done  (m_capture_done),
        .m_triggered_now (m_triggered_now),
        .m_read_data     (m_read_data),
        .m_trigger_place (m_trigger_place),
        .m_armed_flag    (m_armed_flag),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= 50) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    function automatic void store_sample(input logic [SAMPLE_W-1:0] v);
        capture_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
    endfunction

    function automatic void arm_capture();
        phase = PH_ARMED;
        remaining = 11'(STORE_DEPTH);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DAT_W-1:0] data);
        if (idx == REG_TRIGGER_LEVEL) begin
            trig_level = data;
        end else if (idx == REG_TRIGGER_MODE) begin
            trig_mode = data[MODE_W-1:0];
        end else begin
            return;
        end
        // during the first pass only the register changes
        if (phase == PH_FILLING && remaining != 0) return;
        if (trig_mode == MODE_STOP) begin
            phase = PH_FILLING;
            remaining = '0;
        end else begin
            arm_capture();
        end
    endfunction

    function automatic capture_result_t predict_capture(
        input logic [KIND_W-1:0]   kind,
        input logic                ch,
        input logic [SAMPLE_W-1:0] v,
        input logic [INDEX_W-1:0]  idx
    );
        capture_result_t     r;
        logic [SAMPLE_W-1:0] last;
        logic [INDEX_W-1:0]  here;
        logic                crossed;
        r = '0;
        case (kind)
            KIND_SAMPLE: begin
                last = prev_sample[ch];
                prev_sample[ch] = v;
                case (phase)
                    PH_FILLING: begin
                        store_sample(v);
                        if (remaining != 0) begin
                            remaining = remaining - 1'b1;
                            if (remaining == 0 && trig_mode != MODE_STOP) arm_capture();
                        end
                    end
                    PH_ARMED: begin
                        here = wr_ptr;
                        crossed = (v >= trig_level) && (last < trig_level);
                        store_sample(v);
                        if (remaining != 0) remaining = remaining - 1'b1;
                        if (crossed || (trig_mode == MODE_AUTO &&
                                        remaining <= STORE_DEPTH / 2)) begin
                            r.trig = 1'b1;
                            trig_addr = here;
                            phase = PH_POST_TRIGGER;
                            remaining = 11'(STORE_DEPTH / 2 - 1);
                        end else if (remaining == 0) begin
                            remaining = 11'(STORE_DEPTH);
                        end
                    end
                    PH_POST_TRIGGER: begin
                        store_sample(v);
                        if (remaining != 0) remaining = remaining - 1'b1;
                        if (remaining == 0) begin
                            phase = PH_FROZEN;
                            r.done = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_READ: begin
                // trigger sample sits at the middle of the aligned window
                r.data = capture_mem[(int'(trig_addr) + STORE_DEPTH - STORE_DEPTH / 2
                                      + int'(idx)) % STORE_DEPTH];
            end
            KIND_REARM: begin
                if (phase == PH_FROZEN &&
                    (trig_mode == MODE_AUTO || trig_mode == MODE_NORMAL)) arm_capture();
            end
            default: ;
        endcase
        r.place = trig_addr;
        r.armed = (phase == PH_ARMED);
        return r;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0]   kind,
                             input logic                ch,
                             input logic [SAMPLE_W-1:0] v,
                             input logic [INDEX_W-1:0]  idx);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_channel <= ch;
        s_sample_value <= v;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_capture(kind, ch, v, idx));
        words_sent++;
    endtask

    task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] v);
        send_word(KIND_SAMPLE, ch, v, INDEX_W'($urandom));
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] idx);
        send_word(KIND_READ, 1'($urandom), SAMPLE_W'($urandom), idx);
    endtask

    task automatic send_rearm();
        send_word(KIND_REARM, 1'($urandom), SAMPLE_W'($urandom), INDEX_W'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    // ------------------------------------------------------------------
    // result checker and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        capture_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (m_capture_done !== want.done)
                    flag_mismatch($sformatf("word %0d capture_done %b want %b",
                                            words_checked, m_capture_done, want.done));
                if (m_triggered_now !== want.trig)
                    flag_mismatch($sformatf("word %0d triggered_now %b want %b",
                                            words_checked, m_triggered_now, want.trig));
                if (m_read_data !== want.data)
                    flag_mismatch($sformatf("word %0d read_data %0d want %0d",
                                            words_checked, m_read_data, want.data));
                if (m_trigger_place !== want.place)
                    flag_mismatch($sformatf("word %0d trigger_place %0d want %0d",
                                            words_checked, m_trigger_place, want.place));
                if (m_armed_flag !== want.armed)
                    flag_mismatch($sformatf("word %0d armed_flag %b want %b",
                                            words_checked, m_armed_flag, want.armed));
            end
            words_checked++;
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // words and register writes while the first pass is still filling
    task automatic test_fill_and_early_words();
        send_sample(1'b0, 8'd0);
        send_sample(1'b1, 8'd255);
        send_sample(1'b0, 8'd255);
        send_read(10'd512);
        send_read(10'd514);
        send_rearm();
        send_word(KIND_RESERVED, 1'b1, 8'hFF, 10'h3FF);
        write_register(REG_TRIGGER_LEVEL, 8'd200);
        write_register(REG_TRIGGER_MODE, {6'd0, MODE_STOP});
        write_register(8'hFE, 8'hFF);
    endtask

    // first pass ends in stop mode: keeps storing, never arms
    task automatic test_stop_after_first_pass();
        while (phase == PH_FILLING && remaining != 0) begin
            send_sample(1'($urandom), SAMPLE_W'($urandom));
        end
        repeat (4) send_sample(1'($urandom), SAMPLE_W'($urandom));
        send_read(10'd0);
        send_read(10'd1023);
        send_rearm();
        // leave channel 1 high and channel 0 low for the next test
        send_sample(1'b1, 8'd250);
        send_sample(1'b0, 8'd100);
    endtask

    // crossing exactly at the level on one channel, not on the other
    task automatic test_normal_crossing();
        steady = 1'b1;
        write_register(REG_TRIGGER_MODE, {6'd0, MODE_NORMAL});
        send_sample(1'b1, 8'd255);
        send_sample(1'b0, 8'd199);
        send_sample(1'b0, 8'd200);
        while (phase == PH_POST_TRIGGER) send_sample(1'($urandom), SAMPLE_W'($urandom));
        // frozen: samples only move the previous values
        send_sample(1'b0, 8'd0);
        send_sample(1'b1, 8'd255);
        send_read(10'd0);
        send_read(10'd511);
        send_read(10'd512);
        send_read(10'd1023);
        send_rearm();
        steady = 1'b0;
    endtask

    // level at the top so nothing can cross; auto fires after half a store
    task automatic test_auto_timeout();
        write_register(REG_TRIGGER_MODE, {6'd0, MODE_AUTO});
        write_register(REG_TRIGGER_LEVEL, 8'd255);
        while (phase == PH_ARMED) send_sample(1'($urandom), 8'($urandom_range(0, 254)));
        while (phase == PH_POST_TRIGGER) send_sample(1'($urandom), SAMPLE_W'($urandom));
        send_read(10'd512);
        send_read(INDEX_W'($urandom));
        send_rearm();
    endtask

    // single shot: rearm does nothing until a register write
    task automatic test_single_mode();
        write_register(REG_TRIGGER_LEVEL, 8'd0);
        write_register(REG_TRIGGER_MODE, {6'd0, MODE_SINGLE});
        repeat (20) send_sample(1'($urandom), $urandom_range(0, 1) ? 8'd255 : 8'd0);
        write_register(REG_TRIGGER_LEVEL, 8'd1);
        send_sample(1'b0, 8'd0);
        send_sample(1'b0, 8'd1);
        while (phase == PH_POST_TRIGGER) send_sample(1'($urandom), SAMPLE_W'($urandom));
        send_rearm();
        send_sample(1'b1, 8'd77);
        send_read(10'd512);
    endtask

    // ------------------------------------------------------------------
    // random capture rounds
    // ------------------------------------------------------------------
    task automatic test_random_captures();
        int start_words;
        int captures;
        int rounds;
        int style;
        int n;
        int cap;
        int r;
        int v;
        bit froze;
        start_words = words_sent;
        captures = 0;
        rounds = 0;
        froze = 1'b1;
        while ((words_sent - start_words < 300 || captures < 1) && rounds < 30) begin
            rounds++;
            if (!froze || trig_mode == MODE_SINGLE || trig_mode == MODE_STOP ||
                $urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    r = $urandom_range(0, 99);
                    write_register(REG_TRIGGER_LEVEL,
                                   r < 10 ? 8'd0 : r < 20 ? 8'd255 : CFG_DAT_W'($urandom));
                end
                r = $urandom_range(0, 99);
                write_register(REG_TRIGGER_MODE,
                               {6'($urandom), r < 35 ? MODE_AUTO : r < 70 ? MODE_NORMAL :
                                              r < 90 ? MODE_SINGLE : MODE_STOP});
                if ($urandom_range(0, 9) == 0)
                    write_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom));
            end
            style = $urandom_range(0, 3);
            cap = (trig_mode == MODE_STOP) ? 150 : 1100;
            n = 0;
            while (phase != PH_FROZEN && n < cap) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_read(INDEX_W'($urandom));
                end else if (r < 8) begin
                    send_rearm();
                end else if (r < 9) begin
                    send_word(KIND_RESERVED, 1'($urandom), SAMPLE_W'($urandom),
                              INDEX_W'($urandom));
                end else begin
                    case (style)
                        0: v = $urandom_range(0, 255);
                        1: v = int'(trig_level) + $urandom_range(0, 8) - 4;
                        2: v = $urandom_range(0, 1) ? 255 : 0;
                        default: v = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 255)
                                                                  : $urandom_range(0, 40);
                    endcase
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    send_sample(1'($urandom), SAMPLE_W'(v));
                    n++;
                end
            end
            froze = (phase == PH_FROZEN);
            if (froze) begin
                captures++;
                repeat ($urandom_range(0, 4)) send_sample(1'($urandom), SAMPLE_W'($urandom));
                repeat ($urandom_range(4, 24)) send_read(INDEX_W'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    n = $urandom_range(0, 1023);
                    repeat (16) begin
                        send_read(INDEX_W'(n));
                        n++;
                    end
                end
                send_rearm();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_and_early_words();
        test_stop_after_first_pass();
        test_normal_crossing();
        test_auto_timeout();
        test_single_mode();
        test_random_captures();
        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
